/* hdl/tnks_pkg.sv */
// Shared constants, types and the row compare function for the top-N keyed sort.
package tnks_pkg;

  localparam int MAX_ROWS = 32;
  localparam int ADDR_W   = $clog2(MAX_ROWS);
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int IDX_W    = 5;
  localparam int ROW_W    = 8 + 32 + 32 + 32;

  localparam logic [1:0] LIMIT_ALL   = 2'd0;
  localparam logic [1:0] LIMIT_TEN   = 2'd1;
  localparam logic [1:0] LIMIT_FIVE  = 2'd2;
  localparam logic [1:0] LIMIT_THREE = 2'd3;

  localparam logic [1:0] KEY_SIGNAL  = 2'd0;
  localparam logic [1:0] KEY_RECENT  = 2'd1;
  localparam logic [1:0] KEY_IDENT   = 2'd2;
  localparam logic [1:0] KEY_PACKETS = 2'd3;

  localparam logic [1:0] REG_LIMIT_MODE = 2'd0;
  localparam logic [1:0] REG_SORT_KEY   = 2'd1;

  localparam logic [CNT_W-1:0] CAP_TEN   = CNT_W'(10);
  localparam logic [CNT_W-1:0] CAP_FIVE  = CNT_W'(5);
  localparam logic [CNT_W-1:0] CAP_THREE = CNT_W'(3);

  typedef struct packed {
    logic signed [7:0] sig;
    logic [31:0]       tick;
    logic [31:0]       ident;
    logic [31:0]       packets;
  } row_t;

  typedef enum logic [11:0] {
    ST_LOAD       = 12'b0000_0000_0001,
    ST_INIT       = 12'b0000_0000_0010,
    ST_PASS_BEGIN = 12'b0000_0000_0100,
    ST_FETCH_V    = 12'b0000_0000_1000,
    ST_V_DATA     = 12'b0000_0001_0000,
    ST_V_KEY      = 12'b0000_0010_0000,
    ST_RD_ORD     = 12'b0000_0100_0000,
    ST_ORD_WAIT   = 12'b0000_1000_0000,
    ST_CMP        = 12'b0001_0000_0000,
    ST_E_READ     = 12'b0010_0000_0000,
    ST_E_WAIT     = 12'b0100_0000_0000,
    ST_E_HOLD     = 12'b1000_0000_0000
  } state_t;

  // True when row a must move ahead of row b under the given key.
  function automatic logic goes_before(input logic [1:0] key, input row_t a, input row_t b);
    logic [31:0] d;
    logic        res;
    d = a.tick - b.tick;
    unique case (key)
      KEY_RECENT:  res = (d != 32'd0) && !d[31];
      KEY_IDENT:   res = a.ident < b.ident;
      KEY_PACKETS: res = a.packets > b.packets;
      default:     res = a.sig > b.sig;
    endcase
    return res;
  endfunction

endpackage

/* hdl/top_n_then_keyed_sort.sv */
// Top level of the top-N then keyed stable sort of loaded rows.
//
// Rows enter on the row channel (row_valid/row_stall), one per transaction.
// Each accepted row is stored in the row RAM; rows beyond the store capacity
// are dropped. The row with last_row set closes the set and starts sorting;
// row_stall stays high until every result of the set has been delivered.
// A shared compare unit runs an insertion sort driven by a small sequencer,
// with one order RAM and one row RAM, each with one read port. Setup writes
// the identity order into the order RAM; each compare step reads the order
// entry ahead, waits for its row and compares (ST_RD_ORD, ST_ORD_WAIT,
// ST_CMP), and each outer iteration fetches the next row (ST_FETCH_V,
// ST_V_DATA, ST_V_KEY). A top-N cut adds a second pass over N rows.
// Results leave on the result channel (res_valid/res_stall), one transaction
// at a time, the next one read only after the last is taken; a stall holds
// the result in its output register until it is taken. The user must make
// configuration writes through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this. Reset empties the row set
// and sets both registers to zero.
module top_n_then_keyed_sort
  import tnks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [1:0]        cfg_data,
  input  logic              row_valid,
  output logic              row_stall,
  input  logic signed [7:0] signal_level,
  input  logic [31:0]       seen_tick,
  input  logic [31:0]       meter_ident,
  input  logic [31:0]       packet_total,
  input  logic              last_row,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [IDX_W-1:0]  row_index,
  output logic [IDX_W-1:0]  rank,
  output logic              final_res
);

  state_t            state, state_next;
  logic [1:0]        limit_mode, sort_key;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  cap, cap_next;
  logic [CNT_W-1:0]  pass_n, pass_n_next;
  logic [1:0]        pass_key, pass_key_next;
  logic              first_pass, first_pass_next;
  logic [ADDR_W-1:0] i, i_next;
  logic [ADDR_W-1:0] j, j_next;
  logic [ADDR_W-1:0] r, r_next;
  logic              res_valid_next;

  logic [ADDR_W-1:0] v, w;
  row_t              vrow;
  row_t              row_wdata, row_q;
  logic              row_we;

  logic              ord_we;
  logic [ADDR_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_q;

  logic              row_accept;
  logic              res_accept;
  logic [CNT_W-1:0]  i_plus;
  logic [CNT_W-1:0]  r_plus;
  logic [CNT_W-1:0]  cap_sel;

  assign row_stall  = (state != ST_LOAD);
  assign row_accept = row_valid && !row_stall;
  assign res_accept = res_valid && !res_stall;
  assign i_plus     = CNT_W'(i) + CNT_W'(1);
  assign r_plus     = CNT_W'(r) + CNT_W'(1);

  assign row_we    = row_accept && (count < CNT_W'(MAX_ROWS));
  assign row_wdata = '{sig: signal_level, tick: seen_tick, ident: meter_ident,
                       packets: packet_total};

  tnks_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (row_wdata),
    .raddr (ord_q),
    .rdata (row_q)
  );

  tnks_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ROWS)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_q)
  );

  always_comb begin
    unique case (limit_mode)
      LIMIT_TEN:   cap_sel = CAP_TEN;
      LIMIT_FIVE:  cap_sel = CAP_FIVE;
      LIMIT_THREE: cap_sel = CAP_THREE;
      default:     cap_sel = count;
    endcase
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    cap_next        = cap;
    pass_n_next     = pass_n;
    pass_key_next   = pass_key;
    first_pass_next = first_pass;
    i_next          = i;
    j_next          = j;
    r_next          = r;
    res_valid_next  = res_valid;
    ord_we          = 1'b0;
    ord_waddr       = j;
    ord_wdata       = v;
    ord_raddr       = i;

    unique case (state)
      ST_LOAD: begin
        if (row_accept) begin
          if (row_we) begin
            count_next = count + CNT_W'(1);
          end
          if (last_row) begin
            i_next     = '0;
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        ord_we    = 1'b1;
        ord_waddr = i;
        ord_wdata = i;
        if (i_plus == count) begin
          cap_next   = cap_sel;
          pass_n_next = count;
          if (cap_sel < count) begin
            pass_key_next   = KEY_SIGNAL;
            first_pass_next = 1'b1;
          end else begin
            pass_key_next   = sort_key;
            first_pass_next = 1'b0;
          end
          state_next = ST_PASS_BEGIN;
        end else begin
          i_next = i + ADDR_W'(1);
        end
      end
      ST_PASS_BEGIN: begin
        if (pass_n < CNT_W'(2)) begin
          r_next     = '0;
          state_next = ST_E_READ;
        end else begin
          i_next     = ADDR_W'(1);
          state_next = ST_FETCH_V;
        end
      end
      ST_FETCH_V: begin
        ord_raddr  = i;
        state_next = ST_V_DATA;
      end
      ST_V_DATA: begin
        j_next     = i;
        state_next = ST_V_KEY;
      end
      ST_V_KEY: begin
        state_next = ST_RD_ORD;
      end
      ST_RD_ORD: begin
        ord_raddr = j - ADDR_W'(1);
        if (j == '0) begin
          ord_we    = 1'b1;
          ord_waddr = j;
          ord_wdata = v;
          if (i_plus < pass_n) begin
            i_next     = i + ADDR_W'(1);
            state_next = ST_FETCH_V;
          end else if (first_pass) begin
            first_pass_next = 1'b0;
            pass_n_next     = cap;
            pass_key_next   = sort_key;
            state_next      = ST_PASS_BEGIN;
          end else begin
            r_next     = '0;
            state_next = ST_E_READ;
          end
        end else begin
          state_next = ST_ORD_WAIT;
        end
      end
      ST_ORD_WAIT: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        ord_we    = 1'b1;
        ord_waddr = j;
        if (goes_before(pass_key, vrow, row_q)) begin
          ord_wdata  = w;
          j_next     = j - ADDR_W'(1);
          state_next = ST_RD_ORD;
        end else begin
          ord_wdata = v;
          if (i_plus < pass_n) begin
            i_next     = i + ADDR_W'(1);
            state_next = ST_FETCH_V;
          end else if (first_pass) begin
            first_pass_next = 1'b0;
            pass_n_next     = cap;
            pass_key_next   = sort_key;
            state_next      = ST_PASS_BEGIN;
          end else begin
            r_next     = '0;
            state_next = ST_E_READ;
          end
        end
      end
      ST_E_READ: begin
        ord_raddr  = r;
        state_next = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        res_valid_next = 1'b1;
        state_next     = ST_E_HOLD;
      end
      ST_E_HOLD: begin
        if (res_accept) begin
          res_valid_next = 1'b0;
          if (final_res) begin
            count_next = '0;
            state_next = ST_LOAD;
          end else begin
            r_next     = r + ADDR_W'(1);
            state_next = ST_E_READ;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      res_valid  <= 1'b0;
      first_pass <= 1'b0;
      limit_mode <= LIMIT_ALL;
      sort_key   <= KEY_SIGNAL;
    end else begin
      state      <= state_next;
      count      <= count_next;
      res_valid  <= res_valid_next;
      first_pass <= first_pass_next;
      if (cfg_we && (cfg_index == REG_LIMIT_MODE)) begin
        limit_mode <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_SORT_KEY)) begin
        sort_key <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap      <= cap_next;
    pass_n   <= pass_n_next;
    pass_key <= pass_key_next;
    i        <= i_next;
    j        <= j_next;
    r        <= r_next;
    if (state == ST_V_DATA) begin
      v <= ord_q;
    end
    if (state == ST_V_KEY) begin
      vrow <= row_q;
    end
    if (state == ST_ORD_WAIT) begin
      w <= ord_q;
    end
    if (state == ST_E_WAIT) begin
      row_index <= ord_q;
      rank      <= r;
      final_res <= (r_plus == pass_n);
    end
  end

`ifndef SYNTHESIS
  a_valid_in_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == ST_E_HOLD))
    else $error("result valid outside the hold state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ROWS))
    else $error("row count beyond capacity");

  a_final_returns: assert property (@(posedge clk) disable iff (rst)
    (res_accept && final_res) |=> (state == ST_LOAD) && (count == '0))
    else $error("final result did not return the block to loading");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (j <= i) && (j != '0))
    else $error("insertion index out of range");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (i_plus <= pass_n))
    else $error("outer index beyond pass length");
`endif

endmodule

/* hdl/tnks_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tnks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
